// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = ROWS * COLUMNS;

   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int CNT_W       = $clog2(CELL_COUNT + 1);

   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int CELL_W      = 16;
   localparam int CUR_ROW_W   = 5;
   localparam int CUR_COL_W   = 7;
   localparam int COLOR_W     = 8;

   localparam logic [CMD_W-1:0]   CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0]   CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0]   CMD_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK
   } state_type;

endpackage

// ----- rtl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/text_console_writer.sv -----
// Text console writer: a screen of character cells (char low byte, colour high
// byte) held in one synchronous RAM, plus a cursor.
// Request channel (req_valid/req_stall) carries cmd, char_code, cell_index.
// Every accepted item gives exactly one item on the response channel
// (rsp_valid/rsp_stall): cell data for a read, cursor position afterwards and
// a scroll flag.
// Each item's course is set by the single RAM write and read port:
//   put without scroll, unused command: response registered on acceptance
//   read: RAM read issued on acceptance, data returned from ST_READ
//   clear: accept, then ST_CLEAR writes one cell per cycle
//   put that scrolls: accept, then ST_SCROLL copies the rows up with read
//   and write overlapped, then ST_BLANK blanks the bottom row.
// After reset a clearing pass in ST_CLEAR writes blanks in colour 7; no item
// is accepted meanwhile, register writes are.
// The response is held in an output register; a new item is taken in the
// cycle the previous response leaves. While rsp_stall is high the response
// holds and req_stall rises.
// text_color is written over the APB port at byte addresses 0 to 3 (paddr[2] low).
module text_console_writer (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]       req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]     req_cell_index,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]      rsp_cell_data,
   output logic [tcw_pkg::CUR_ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::CUR_COL_W-1:0]   rsp_cursor_col,
   output logic                            rsp_did_scroll,

   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcw_pkg::PADDR_W-1:0]     paddr,
   input  logic [tcw_pkg::PDATA_W-1:0]     pwdata,
   output logic [tcw_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int CNT_W  = tcw_pkg::CNT_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;

   tcw_pkg::state_type state_ff, state_in;

   logic [ROW_W-1:0]              row_ff, row_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ADDR_W-1:0]             base_ff, base_in;
   logic [CNT_W-1:0]              sweep_ff, sweep_in;
   logic [tcw_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic [tcw_pkg::COLOR_W-1:0]   fill_color_ff, fill_color_in;
   logic                          clear_rsp_ff, clear_rsp_in;
   logic                          read_ok_ff, read_ok_in;
   logic                          copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]             copy_addr_ff, copy_addr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [tcw_pkg::CUR_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::CUR_COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic                          rsp_scroll_ff, rsp_scroll_in;

   logic                          mem_we, mem_re;
   logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]    mem_wdata, mem_rdata;

   logic accept, cfg_write, is_newline, at_line_end, at_bottom, put_wrap, put_scroll;
   logic sweep_last, sweep_end, index_ok;

   tcw_cell_ram #(
      .DEPTH (tcw_pkg::CELL_COUNT),
      .WIDTH (tcw_pkg::CELL_W)
   ) u_cell_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_stall   = (state_ff != tcw_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign is_newline  = (req_char_code == tcw_pkg::NEWLINE_CODE);
   assign at_line_end = (col_ff == COL_W'(tcw_pkg::COLUMNS - 1));
   assign at_bottom   = (row_ff == ROW_W'(tcw_pkg::ROWS - 1));
   assign put_wrap    = is_newline || at_line_end;
   assign put_scroll  = put_wrap && at_bottom;
   assign sweep_last  = (sweep_ff == CNT_W'(tcw_pkg::CELL_COUNT - 1));
   assign sweep_end   = (sweep_ff == CNT_W'(tcw_pkg::CELL_COUNT));
   assign index_ok    = (32'(req_cell_index) < 32'(tcw_pkg::CELL_COUNT));

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == tcw_pkg::REG_TEXT_COLOR) ?
                      tcw_pkg::PDATA_W'(color_ff) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (sweep_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  tcw_pkg::CMD_PUT: begin
                     if (put_scroll) begin
                        state_in = tcw_pkg::ST_SCROLL;
                     end
                  end
                  tcw_pkg::CMD_READ:  state_in = tcw_pkg::ST_READ;
                  tcw_pkg::CMD_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  default:            state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         tcw_pkg::ST_READ:   state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_SCROLL: begin
            if (sweep_end) begin
               state_in = tcw_pkg::ST_BLANK;
            end
         end
         tcw_pkg::ST_BLANK: begin
            if (sweep_last) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      row_in        = row_ff;
      col_in        = col_ff;
      base_in       = base_ff;
      sweep_in      = sweep_ff;
      color_in      = color_ff;
      fill_color_in = fill_color_ff;
      clear_rsp_in  = clear_rsp_ff;
      read_ok_in    = read_ok_ff;
      copy_pend_in  = 1'b0;
      copy_addr_in  = copy_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_scroll_in = rsp_scroll_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      if (cfg_write && paddr[2] == tcw_pkg::REG_TEXT_COLOR) begin
         color_in = pwdata[tcw_pkg::COLOR_W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // row copy writes in the cycle after its read
      if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = mem_rdata;
      end

      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[ADDR_W-1:0];
            mem_wdata = {fill_color_ff, tcw_pkg::BLANK_CODE};
            sweep_in  = sweep_ff + CNT_W'(1);
            if (sweep_last) begin
               clear_rsp_in = 1'b0;
               if (clear_rsp_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  rsp_row_in    = tcw_pkg::CUR_ROW_W'(row_ff);
                  rsp_col_in    = tcw_pkg::CUR_COL_W'(col_ff);
                  rsp_scroll_in = 1'b0;
               end
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  tcw_pkg::CMD_PUT: begin
                     if (!is_newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = base_ff + ADDR_W'(col_ff);
                        mem_wdata = {color_ff, req_char_code};
                     end
                     if (put_wrap) begin
                        col_in = '0;
                        if (!at_bottom) begin
                           row_in  = row_ff + ROW_W'(1);
                           base_in = base_ff + ADDR_W'(tcw_pkg::COLUMNS);
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                     if (put_scroll) begin
                        sweep_in      = CNT_W'(tcw_pkg::COLUMNS);
                        fill_color_in = color_ff;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_row_in    = tcw_pkg::CUR_ROW_W'(row_in);
                        rsp_col_in    = tcw_pkg::CUR_COL_W'(col_in);
                        rsp_scroll_in = 1'b0;
                     end
                  end
                  tcw_pkg::CMD_READ: begin
                     mem_re     = index_ok;
                     mem_raddr  = ADDR_W'(req_cell_index);
                     read_ok_in = index_ok;
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     sweep_in      = '0;
                     fill_color_in = color_ff;
                     clear_rsp_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_row_in    = tcw_pkg::CUR_ROW_W'(row_ff);
                     rsp_col_in    = tcw_pkg::CUR_COL_W'(col_ff);
                     rsp_scroll_in = 1'b0;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = read_ok_ff ? mem_rdata : '0;
            rsp_row_in    = tcw_pkg::CUR_ROW_W'(row_ff);
            rsp_col_in    = tcw_pkg::CUR_COL_W'(col_ff);
            rsp_scroll_in = 1'b0;
         end
         tcw_pkg::ST_SCROLL: begin
            if (sweep_end) begin
               sweep_in = CNT_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
            end else begin
               mem_re       = 1'b1;
               mem_raddr    = sweep_ff[ADDR_W-1:0];
               copy_pend_in = 1'b1;
               copy_addr_in = ADDR_W'(sweep_ff - CNT_W'(tcw_pkg::COLUMNS));
               sweep_in     = sweep_ff + CNT_W'(1);
            end
         end
         tcw_pkg::ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[ADDR_W-1:0];
            mem_wdata = {fill_color_ff, tcw_pkg::BLANK_CODE};
            sweep_in  = sweep_ff + CNT_W'(1);
            if (sweep_last) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_row_in    = tcw_pkg::CUR_ROW_W'(row_ff);
               rsp_col_in    = tcw_pkg::CUR_COL_W'(col_ff);
               rsp_scroll_in = 1'b1;
            end
         end
         default: begin
            sweep_in = sweep_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_CLEAR;
         row_ff        <= '0;
         col_ff        <= '0;
         base_ff       <= '0;
         sweep_ff      <= '0;
         color_ff      <= tcw_pkg::RESET_COLOR;
         fill_color_ff <= tcw_pkg::RESET_COLOR;
         clear_rsp_ff  <= 1'b0;
         read_ok_ff    <= 1'b0;
         copy_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         base_ff       <= base_in;
         sweep_ff      <= sweep_in;
         color_ff      <= color_in;
         fill_color_ff <= fill_color_in;
         clear_rsp_ff  <= clear_rsp_in;
         read_ok_ff    <= read_ok_in;
         copy_pend_ff  <= copy_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff  <= copy_addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_scroll_ff <= rsp_scroll_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_did_scroll = rsp_scroll_ff;

   a_sweep_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_CLEAR || state_ff == tcw_pkg::ST_SCROLL ||
       state_ff == tcw_pkg::ST_BLANK) |-> !rsp_valid_ff)
      else $error("response pending during screen sweep");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(tcw_pkg::ROWS)) && (32'(col_ff) < 32'(tcw_pkg::COLUMNS)))
      else $error("cursor out of screen");

   a_row_base: assert property (@(posedge clock) disable iff (reset)
      32'(base_ff) == 32'(row_ff) * 32'(tcw_pkg::COLUMNS))
      else $error("row base address out of step with cursor row");

   a_read_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == tcw_pkg::CMD_READ) |=> (state_ff == tcw_pkg::ST_READ))
      else $error("read item not followed by read cycle");

   a_copy_only_scroll: assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> (state_ff == tcw_pkg::ST_SCROLL))
      else $error("row copy write outside scroll");

endmodule
